// ===== hdl/iac_pkg.sv =====
// shared types and constants for the intrusion alarm controller
package iac_pkg;

    localparam int unsigned CfgDataW = 32;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned LongW    = 32;
    localparam int unsigned ShortW   = 16;

    localparam logic [LongW-1:0]  HoldoffReset = 32'd60000;
    localparam logic [LongW-1:0]  SoundReset   = 32'd10000;
    localparam logic [ShortW-1:0] ChirpReset   = 16'd500;
    localparam logic [ShortW-1:0] PollReset    = 16'd1000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HOLDOFF = 2'd0,
        REG_SOUND   = 2'd1,
        REG_CHIRP   = 2'd2,
        REG_POLL    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_TOGGLE = 2'd1,
        ACT_REMOTE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CH_IDLE  = 2'd0,
        CH_LAST  = 2'd1,
        CH_GAP   = 2'd2,
        CH_FIRST = 2'd3
    } t_chirp;

    typedef struct packed {
        logic [LongW-1:0]  holdoff_ms;
        logic [LongW-1:0]  sound_ms;
        logic [ShortW-1:0] chirp_ms;
        logic [ShortW-1:0] poll_ms;
    } t_cfg;

    typedef struct packed {
        logic siren_drive;
        logic armed_flag;
        logic sounding_flag;
        logic report_armed;
    } t_result;

endpackage

// ===== hdl/intrusion_alarm_controller.sv =====
// intrusion alarm controller top level
// One input beat is one millisecond tick; the block takes a beat every cycle and its
// result is in the output register in the cycle after. A beat is held off only while
// that register is full and the output side stalls. State update for a tick is one pass
// through the counter and chirp logic, so with no stall the rate is one beat per cycle.
module intrusion_alarm_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [iac_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [iac_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_in_action,
    input  logic                         i_in_remote_value,
    input  logic                         i_in_sensor_level,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_out_siren_drive,
    output logic                         o_out_armed_flag,
    output logic                         o_out_sounding_flag,
    output logic                         o_out_report_armed
);
    import iac_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    iac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iac_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_action       (i_in_action),
        .i_remote_value (i_in_remote_value),
        .i_sensor_level (i_in_sensor_level),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_siren_drive   = r_result.siren_drive;
    assign o_out_armed_flag    = r_result.armed_flag;
    assign o_out_sounding_flag = r_result.sounding_flag;
    assign o_out_report_armed  = r_result.report_armed;
endmodule

// ===== hdl/iac_cfg.sv =====
// configuration register bank
module iac_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [iac_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [iac_pkg::CfgDataW-1:0] i_cfg_data,
    output iac_pkg::t_cfg                o_cfg
);
    import iac_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff_ms <= HoldoffReset;
            r_cfg.sound_ms   <= SoundReset;
            r_cfg.chirp_ms   <= ChirpReset;
            r_cfg.poll_ms    <= PollReset;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_HOLDOFF: r_cfg.holdoff_ms <= i_cfg_data;
                REG_SOUND:   r_cfg.sound_ms   <= i_cfg_data;
                REG_CHIRP:   r_cfg.chirp_ms   <= i_cfg_data[ShortW-1:0];
                REG_POLL:    r_cfg.poll_ms    <= i_cfg_data[ShortW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hdl/iac_core.sv =====
// alarm state and per-tick update
module iac_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iac_pkg::t_cfg    i_cfg,
    input  logic             i_accept,
    input  logic [1:0]       i_action,
    input  logic             i_remote_value,
    input  logic             i_sensor_level,
    output iac_pkg::t_result o_result
);
    import iac_pkg::*;

    logic              r_armed, n_armed;
    logic              r_sounding, n_sounding;
    logic [LongW-1:0]  r_since_alert, n_since_alert;
    logic [LongW-1:0]  r_sound_elapsed, n_sound_elapsed;
    logic [ShortW-1:0] r_poll_count, n_poll_count;
    t_chirp            r_chirp_phase, n_chirp_phase;
    logic [ShortW-1:0] r_chirp_timer, n_chirp_timer;
    logic              report;
    logic              chirp_on;

    always_comb begin
        n_armed         = r_armed;
        n_sounding      = r_sounding;
        n_chirp_phase   = r_chirp_phase;
        n_chirp_timer   = r_chirp_timer;
        report          = 1'b0;

        // event
        case (t_action'(i_action))
            ACT_TOGGLE: begin
                n_armed       = !r_armed;
                n_chirp_phase = !r_armed ? CH_LAST : CH_FIRST;
                n_chirp_timer = '0;
                report        = 1'b1;
            end
            ACT_REMOTE: begin
                n_armed       = i_remote_value;
                n_chirp_phase = i_remote_value ? CH_LAST : CH_FIRST;
                n_chirp_timer = '0;
                if (!i_remote_value) begin
                    n_sounding = 1'b0;
                end
                report        = 1'b1;
            end
            default: ;
        endcase

        // saturating counters
        n_since_alert = (r_since_alert == '1) ? r_since_alert : r_since_alert + 1'b1;
        n_sound_elapsed = r_sound_elapsed;
        if (n_sounding && r_sound_elapsed != '1) begin
            n_sound_elapsed = r_sound_elapsed + 1'b1;
        end

        // poll
        n_poll_count = r_poll_count + 1'b1;
        if (n_poll_count >= i_cfg.poll_ms) begin
            n_poll_count = '0;
            if (n_armed && i_sensor_level && !n_sounding
                    && n_since_alert > i_cfg.holdoff_ms) begin
                n_sounding      = 1'b1;
                n_sound_elapsed = '0;
                n_since_alert   = '0;
            end
            if (n_sounding && n_sound_elapsed > i_cfg.sound_ms) begin
                n_sounding = 1'b0;
            end
        end

        // chirp sequencer
        chirp_on = (n_chirp_phase == CH_LAST) || (n_chirp_phase == CH_FIRST);
        if (n_chirp_phase != CH_IDLE) begin
            n_chirp_timer = n_chirp_timer + 1'b1;
            if (n_chirp_timer >= i_cfg.chirp_ms) begin
                n_chirp_timer = '0;
                case (n_chirp_phase)
                    CH_FIRST: n_chirp_phase = CH_GAP;
                    CH_GAP:   n_chirp_phase = CH_LAST;
                    default:  n_chirp_phase = CH_IDLE;
                endcase
            end
        end else begin
            n_chirp_timer = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed         <= 1'b0;
            r_sounding      <= 1'b0;
            r_since_alert   <= '0;
            r_sound_elapsed <= '0;
            r_poll_count    <= '0;
            r_chirp_phase   <= CH_IDLE;
            r_chirp_timer   <= '0;
        end else if (i_accept) begin
            r_armed         <= n_armed;
            r_sounding      <= n_sounding;
            r_since_alert   <= n_since_alert;
            r_sound_elapsed <= n_sound_elapsed;
            r_poll_count    <= n_poll_count;
            r_chirp_phase   <= n_chirp_phase;
            r_chirp_timer   <= n_chirp_timer;
        end
    end

    assign o_result.siren_drive   = n_sounding | chirp_on;
    assign o_result.armed_flag    = n_armed;
    assign o_result.sounding_flag = n_sounding;
    assign o_result.report_armed  = report;
endmodule

// ===== hdl/iac_chk.sv =====
// port-level checks for the intrusion alarm controller
module iac_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_in_action,
    input logic       i_in_remote_value,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_out_siren_drive,
    input logic       o_out_armed_flag,
    input logic       o_out_sounding_flag,
    input logic       o_out_report_armed
);
    import iac_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_siren_drive)
            && $stable(o_out_armed_flag) && $stable(o_out_sounding_flag)
            && $stable(o_out_report_armed)))
        else $error("stalled output beat changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_siren_when_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_sounding_flag) |-> o_out_siren_drive)
        else $error("sounding without siren drive");

    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_out_valid && (o_out_report_armed ==
            ($past(i_in_action) == ACT_TOGGLE || $past(i_in_action) == ACT_REMOTE))))
        else $error("report flag does not match event");

    a_remote_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_action == ACT_REMOTE && !i_in_remote_value)
            |=> (!o_out_armed_flag && !o_out_sounding_flag))
        else $error("remote disarm left alarm armed or sounding");
endmodule

bind intrusion_alarm_controller iac_chk u_iac_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .i_in_action         (i_in_action),
    .i_in_remote_value   (i_in_remote_value),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_out_siren_drive   (o_out_siren_drive),
    .o_out_armed_flag    (o_out_armed_flag),
    .o_out_sounding_flag (o_out_sounding_flag),
    .o_out_report_armed  (o_out_report_armed)
);

// ===== bench/intrusion_alarm_controller_tb.sv =====
// self-checking bench for the intrusion alarm controller: directed script, then random ticks
module intrusion_alarm_controller_tb;
    import iac_pkg::*;

    localparam logic [1:0] ActUnused = 2'd3;
    localparam int         ScriptLen = 31;
    localparam int         Phases    = 8;
    localparam int         PhaseLen  = 230;

    typedef struct packed {
        logic             is_cfg;
        t_reg_idx         idx;
        logic [LongW-1:0] data;
        logic [1:0]       act;
        logic             rv;
        logic             sensor;
        logic             typed;
        t_result          status;
    } t_script_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_in_action;
    logic                i_in_remote_value;
    logic                i_in_sensor_level;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_out_siren_drive;
    logic                o_out_armed_flag;
    logic                o_out_sounding_flag;
    logic                o_out_report_armed;

    // alarm state mirrored by the predictor
    t_cfg              m_cfg;
    logic              m_armed;
    logic              m_sounding;
    logic [LongW-1:0]  m_since_alert;
    logic [LongW-1:0]  m_sound_elapsed;
    logic [ShortW-1:0] m_poll_cnt;
    t_chirp            m_chirp;
    logic [ShortW-1:0] m_chirp_timer;

    t_result alarm_status_q[$];
    int      burst_left;
    int      ticks_sent;
    int      status_checked;
    int      alerts_raised;
    int      settings_used;
    int      mismatch_count;

    t_script_row script [0:ScriptLen-1] = '{
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b0, 1'b1, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b1, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ActUnused,  1'b1, 1'b1, 1'b1, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TOGGLE, 1'b0, 1'b0, 1'b1, 4'b1101},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b0, 1'b1, 4'b1100},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b1, 1'b0, 1'b1, 4'b1101},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b0, 1'b0, 1'b1, 4'b1001},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TOGGLE, 1'b0, 1'b0, 1'b1, 4'b1101},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TOGGLE, 1'b0, 1'b0, 1'b1, 4'b1001},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b1, 1'b1, 1'b1, 4'b1101},
        // zero holdoff, duration, chirp and poll
        '{1'b1, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_SOUND,   32'd0, ACT_TICK,   1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_CHIRP,   32'd0, ACT_TICK,   1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_POLL,    32'd0, ACT_TICK,   1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TOGGLE, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        // all-ones registers
        '{1'b1, REG_HOLDOFF, 32'hFFFF_FFFF, ACT_TICK, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_SOUND,   32'hFFFF_FFFF, ACT_TICK, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_CHIRP,   32'h0000_FFFF, ACT_TICK, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b1, REG_POLL,    32'h0000_FFFF, ACT_TICK, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TOGGLE, 1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_TICK,   1'b0, 1'b1, 1'b0, 4'b0000},
        '{1'b0, REG_HOLDOFF, 32'd0, ACT_REMOTE, 1'b0, 1'b1, 1'b0, 4'b0000}
    };

    intrusion_alarm_controller u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_action         (i_in_action),
        .i_in_remote_value   (i_in_remote_value),
        .i_in_sensor_level   (i_in_sensor_level),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_siren_drive   (o_out_siren_drive),
        .o_out_armed_flag    (o_out_armed_flag),
        .o_out_sounding_flag (o_out_sounding_flag),
        .o_out_report_armed  (o_out_report_armed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_result tick_alarm(input logic [1:0] act, input logic rv,
                                           input logic sensor);
        t_result res;
        logic    chirp_on;
        res.report_armed = 1'b0;
        if (act == ACT_TOGGLE) begin
            m_armed          = ~m_armed;
            m_chirp          = m_armed ? CH_LAST : CH_FIRST;
            m_chirp_timer    = '0;
            res.report_armed = 1'b1;
        end else if (act == ACT_REMOTE) begin
            m_armed = rv;
            if (!rv) begin
                m_sounding = 1'b0;
            end
            m_chirp          = rv ? CH_LAST : CH_FIRST;
            m_chirp_timer    = '0;
            res.report_armed = 1'b1;
        end
        if (m_since_alert != '1) begin
            m_since_alert = m_since_alert + 1'b1;
        end
        if (m_sounding && m_sound_elapsed != '1) begin
            m_sound_elapsed = m_sound_elapsed + 1'b1;
        end
        m_poll_cnt = m_poll_cnt + 1'b1;
        if (m_poll_cnt >= m_cfg.poll_ms) begin
            m_poll_cnt = '0;
            if (m_armed && sensor && !m_sounding && m_since_alert > m_cfg.holdoff_ms) begin
                m_sounding      = 1'b1;
                m_sound_elapsed = '0;
                m_since_alert   = '0;
                alerts_raised++;
            end
            if (m_sounding && m_sound_elapsed > m_cfg.sound_ms) begin
                m_sounding = 1'b0;
            end
        end
        chirp_on = (m_chirp == CH_LAST) || (m_chirp == CH_FIRST);
        if (m_chirp != CH_IDLE) begin
            m_chirp_timer = m_chirp_timer + 1'b1;
            if (m_chirp_timer >= m_cfg.chirp_ms) begin
                m_chirp_timer = '0;
                m_chirp       = t_chirp'(m_chirp - 2'd1);
            end
        end else begin
            m_chirp_timer = '0;
        end
        res.siren_drive   = m_sounding | chirp_on;
        res.armed_flag    = m_armed;
        res.sounding_flag = m_sounding;
        return res;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic [1:0] act, input logic rv, input logic sensor,
                             input logic typed, input t_result typed_status);
        t_result res;
        int      gap;
        int      pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                burst_left = $urandom_range(100, 200);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap        = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 12);
            end
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid        = 1'b1;
        i_in_action       = act;
        i_in_remote_value = rv;
        i_in_sensor_level = sensor;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = tick_alarm(act, rv, sensor);
        alarm_status_q.push_back(typed ? typed_status : res);
        ticks_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        i_in_valid = 1'b0;
        while (alarm_status_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [LongW-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_HOLDOFF: m_cfg.holdoff_ms = data;
            REG_SOUND:   m_cfg.sound_ms   = data;
            REG_CHIRP:   m_cfg.chirp_ms   = data[ShortW-1:0];
            REG_POLL:    m_cfg.poll_ms    = data[ShortW-1:0];
            default:     ;
        endcase
    endtask

    task automatic compare_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("status beat %0d: %s expected %b, got %b",
                         status_checked, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (alarm_status_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("status beat with nothing pending");
                end
            end else begin
                want = alarm_status_q.pop_front();
                compare_field("siren_drive", want.siren_drive, o_out_siren_drive);
                compare_field("armed_flag", want.armed_flag, o_out_armed_flag);
                compare_field("sounding_flag", want.sounding_flag, o_out_sounding_flag);
                compare_field("report_armed", want.report_armed, o_out_report_armed);
            end
            status_checked++;
        end
    end

    // output side stall pattern
    initial begin
        int mode;
        int span;
        int k;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((k % 5) < 2);
                endcase
            end
        end
    end

    initial begin
        int         ph;
        int         n;
        int         pick;
        logic [1:0] act;
        logic       rv;
        logic       sensor;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = REG_HOLDOFF;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_in_action       = ACT_TICK;
        i_in_remote_value = 1'b0;
        i_in_sensor_level = 1'b0;
        m_cfg             = '{HoldoffReset, SoundReset, ChirpReset, PollReset};
        m_armed           = 1'b0;
        m_sounding        = 1'b0;
        m_since_alert     = '0;
        m_sound_elapsed   = '0;
        m_poll_cnt        = '0;
        m_chirp           = CH_IDLE;
        m_chirp_timer     = '0;
        burst_left        = 0;
        ticks_sent        = 0;
        status_checked    = 0;
        alerts_raised     = 0;
        settings_used     = 1;
        mismatch_count    = 0;
        sensor            = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                wait_quiet();
                program_reg(script[k].idx, script[k].data);
                settings_used++;
            end else begin
                send_tick(script[k].act, script[k].rv, script[k].sensor,
                          script[k].typed, script[k].status);
            end
        end

        for (ph = 0; ph < Phases; ph++) begin
            wait_quiet();
            case (ph)
                0: begin
                    program_reg(REG_HOLDOFF, 32'd0);
                    program_reg(REG_SOUND, 32'hFFFF_FFFF);
                    program_reg(REG_CHIRP, 32'd1);
                    program_reg(REG_POLL, 32'd1);
                end
                Phases - 1: begin
                    program_reg(REG_HOLDOFF, 32'd5);
                    program_reg(REG_SOUND, 32'd0);
                    program_reg(REG_CHIRP, 32'd1);
                    program_reg(REG_POLL, 32'd0);
                end
                default: begin
                    program_reg(REG_HOLDOFF, $urandom_range(0, 80));
                    program_reg(REG_SOUND, $urandom_range(0, 60));
                    program_reg(REG_CHIRP, $urandom_range(0, 12));
                    program_reg(REG_POLL, $urandom_range(0, 8));
                end
            endcase
            settings_used++;
            for (n = 0; n < PhaseLen; n++) begin
                pick = $urandom_range(0, 99);
                act  = (pick < 78) ? ACT_TICK : (pick < 85) ? ACT_TOGGLE :
                       (pick < 97) ? ACT_REMOTE : ActUnused;
                rv   = ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 9) == 0) begin
                    sensor = ~sensor;
                end
                send_tick(act, rv, sensor, 1'b0, '0);
            end
        end

        i_in_valid = 1'b0;
        while (alarm_status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        $display("%0d ticks under %0d register settings, %0d status beats checked",
                 ticks_sent, settings_used, status_checked);
        $display("%0d alerts raised, %0d mismatches", alerts_raised, mismatch_count);
        if (mismatch_count == 0 && alarm_status_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/iac_pkg.sv
hdl/iac_cfg.sv
hdl/iac_core.sv
hdl/intrusion_alarm_controller.sv
hdl/iac_chk.sv
bench/intrusion_alarm_controller_tb.sv
